// ----- rtl/range_scan_stream_decoder_assert.svh -----
// assertion macros shared by the range scan decoder modules
// expects signals clk and rst_n in the module that uses them
`ifndef RANGE_SCAN_STREAM_DECODER_ASSERT_SVH
`define RANGE_SCAN_STREAM_DECODER_ASSERT_SVH

// condition holds at every edge outside reset
`define RSSD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define RSSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rssd_pkg.sv -----
// types and constants of the range scan stream decoder
// used by every module of the block, no dependencies
package rssd_pkg;

    localparam int MAX_POINTS  = 1081;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_FEED    = 8'h0A;
    localparam logic [5:0] DIGIT_BIAS = 6'h30;
    localparam logic [2:0] GROUP_LEN  = 3'd6;

    localparam logic KIND_POINT = 1'b0;
    localparam logic KIND_END   = 1'b1;

    localparam logic CFG_HEADER_LINES    = 1'b0;
    localparam logic CFG_EXPECTED_POINTS = 1'b1;

    localparam logic [2:0]  HEADER_LINES_RST    = 3'd3;
    localparam logic [10:0] EXPECTED_POINTS_RST = 11'd641;

    typedef enum logic {
        CMD_DIGIT,
        CMD_END
    } rssd_cmd_kind_t;

    typedef struct packed {
        rssd_cmd_kind_t kind;
        logic [7:0]     char;
    } rssd_cmd_t;

endpackage

// ----- rtl/rssd_front.sv -----
// front end: skips header lines, drops checksum characters, detects end of scan
// depends on rssd_pkg, feeds commands into rssd_queue
module rssd_front
    import rssd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    input  logic [2:0] header_lines,
    output logic       push,
    output rssd_cmd_t  cmd
);

    logic [2:0] header_count_reg, header_count_next;
    logic [7:0] held_char_reg, held_char_next;
    logic       held_valid_reg, held_valid_next;
    logic       last_was_feed_reg, last_was_feed_next;
    logic       is_feed;
    logic [2:0] header_inc;

    assign is_feed    = (rx_byte == CH_FEED);
    assign header_inc = header_count_reg + 3'd1;

    always_comb
    begin
        header_count_next  = header_count_reg;
        held_char_next     = held_char_reg;
        held_valid_next    = held_valid_reg;
        last_was_feed_next = last_was_feed_reg;
        push               = 1'b0;
        cmd.kind           = CMD_DIGIT;
        cmd.char           = held_char_reg;
        if (accept)
        begin
            priority if (header_count_reg < header_lines)
            begin
                if (is_feed)
                begin
                    header_count_next = header_inc;
                    if (header_inc >= header_lines)
                    begin
                        last_was_feed_next = 1'b1;
                    end
                end
            end
            else if (is_feed)
            begin
                if (last_was_feed_reg)
                begin
                    push               = 1'b1;
                    cmd.kind           = CMD_END;
                    header_count_next  = 3'd0;
                    held_char_next     = 8'd0;
                    held_valid_next    = 1'b0;
                    last_was_feed_next = 1'b0;
                end
                else
                begin
                    held_valid_next    = 1'b0;
                    last_was_feed_next = 1'b1;
                end
            end
            else
            begin
                push               = held_valid_reg;
                held_char_next     = rx_byte;
                held_valid_next    = 1'b1;
                last_was_feed_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg  <= 3'd0;
            held_char_reg     <= 8'd0;
            held_valid_reg    <= 1'b0;
            last_was_feed_reg <= 1'b0;
        end
        else
        begin
            header_count_reg  <= header_count_next;
            held_char_reg     <= held_char_next;
            held_valid_reg    <= held_valid_next;
            last_was_feed_reg <= last_was_feed_next;
        end
    end

endmodule

// ----- rtl/rssd_queue.sv -----
// short command queue between front end and group decoder
// depends on rssd_pkg
`include "range_scan_stream_decoder_assert.svh"
module rssd_queue
    import rssd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  rssd_cmd_t push_cmd,
    output logic      full,
    input  logic      pop,
    output logic      pop_valid,
    output rssd_cmd_t pop_cmd
);

    rssd_cmd_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push, do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + QCNT_W'(1);
                2'b01:   count_reg <= count_reg - QCNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    `RSSD_ASSERT_ALWAYS(a_count_bound, count_reg <= QCNT_W'(QUEUE_DEPTH), "queue count overrun")
    `RSSD_ASSERT_NEXT(a_count_up, do_push && !do_pop, count_reg == $past(count_reg) + QCNT_W'(1), "queue count missed a push")
    `RSSD_ASSERT_NEXT(a_count_down, do_pop && !do_push, count_reg == $past(count_reg) - QCNT_W'(1), "queue count missed a pop")

endmodule

// ----- rtl/rssd_back.sv -----
// group decoder: packs digits into point pairs, counts points, emits the verdict
// depends on rssd_pkg, drains rssd_queue and drives the output register
`include "range_scan_stream_decoder_assert.svh"
module rssd_back
    import rssd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cmd_valid,
    input  rssd_cmd_t    cmd,
    output logic         cmd_pop,
    input  logic [10:0]  expected_points,
    output logic         out_valid,
    input  logic         out_ready,
    output logic         kind,
    output logic [10:0]  point_index,
    output logic [17:0]  distance,
    output logic [17:0]  strength,
    output logic         scan_ok
);

    logic [2:0]  digit_phase_reg, digit_phase_next;
    logic [35:0] pair_shift_reg, pair_shift_next;
    logic [10:0] points_seen_reg, points_seen_next;
    logic        overflow_reg, overflow_next;

    logic        out_valid_reg, out_valid_next;
    logic        kind_reg, kind_next;
    logic [10:0] point_index_reg, point_index_next;
    logic [17:0] distance_reg, distance_next;
    logic [17:0] strength_reg, strength_next;
    logic        scan_ok_reg, scan_ok_next;

    logic        slot_free;
    logic [5:0]  digit;
    logic [35:0] shifted;
    logic [2:0]  phase_inc;
    logic        room;

    assign slot_free = !out_valid_reg || out_ready;
    assign cmd_pop   = cmd_valid && slot_free;
    assign digit     = cmd.char[5:0] - DIGIT_BIAS;
    assign shifted   = {pair_shift_reg[29:0], digit};
    assign phase_inc = digit_phase_reg + 3'd1;
    assign room      = (points_seen_reg < expected_points)
                    && (points_seen_reg < 11'(MAX_POINTS));

    always_comb
    begin
        digit_phase_next = digit_phase_reg;
        pair_shift_next  = pair_shift_reg;
        points_seen_next = points_seen_reg;
        overflow_next    = overflow_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        kind_next        = kind_reg;
        point_index_next = point_index_reg;
        distance_next    = distance_reg;
        strength_next    = strength_reg;
        scan_ok_next     = scan_ok_reg;
        if (cmd_pop)
        begin
            unique case (cmd.kind)
                CMD_DIGIT:
                begin
                    pair_shift_next = shifted;
                    if (phase_inc == GROUP_LEN)
                    begin
                        digit_phase_next = 3'd0;
                        if (room)
                        begin
                            out_valid_next   = 1'b1;
                            kind_next        = KIND_POINT;
                            point_index_next = points_seen_reg;
                            distance_next    = shifted[35:18];
                            strength_next    = shifted[17:0];
                            scan_ok_next     = 1'b0;
                            points_seen_next = points_seen_reg + 11'd1;
                        end
                        else
                        begin
                            overflow_next = 1'b1;
                        end
                    end
                    else
                    begin
                        digit_phase_next = phase_inc;
                    end
                end
                CMD_END:
                begin
                    out_valid_next   = 1'b1;
                    kind_next        = KIND_END;
                    point_index_next = points_seen_reg;
                    distance_next    = 18'd0;
                    strength_next    = 18'd0;
                    scan_ok_next     = !overflow_reg && (digit_phase_reg == 3'd0)
                                    && (points_seen_reg == expected_points);
                    digit_phase_next = 3'd0;
                    pair_shift_next  = 36'd0;
                    points_seen_next = 11'd0;
                    overflow_next    = 1'b0;
                end
                default:
                begin
                    out_valid_next = out_valid_reg && !out_ready;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_phase_reg <= 3'd0;
            pair_shift_reg  <= 36'd0;
            points_seen_reg <= 11'd0;
            overflow_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            digit_phase_reg <= digit_phase_next;
            pair_shift_reg  <= pair_shift_next;
            points_seen_reg <= points_seen_next;
            overflow_reg    <= overflow_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        point_index_reg <= point_index_next;
        distance_reg    <= distance_next;
        strength_reg    <= strength_next;
        scan_ok_reg     <= scan_ok_next;
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign point_index = point_index_reg;
    assign distance    = distance_reg;
    assign strength    = strength_reg;
    assign scan_ok     = scan_ok_reg;

    `RSSD_ASSERT_ALWAYS(a_phase_bound, digit_phase_reg < GROUP_LEN, "digit phase past group length")
    `RSSD_ASSERT_ALWAYS(a_count_bound, points_seen_reg <= 11'(MAX_POINTS), "point count past maximum")
    `RSSD_ASSERT_NEXT(a_end_emits, cmd_pop && (cmd.kind == CMD_END), out_valid_reg && (kind_reg == KIND_END) && (points_seen_reg == 11'd0), "end request lost")

endmodule

// ----- rtl/range_scan_stream_decoder.sv -----
// range scan stream decoder: turns scanner reply bytes into point pairs
// and an end of scan verdict
// depends on rssd_pkg, rssd_front, rssd_queue, rssd_back
//
// input channel: in_valid/in_ready with rx_byte, one reply character a request
// output channel: out_valid/out_ready with kind, point_index, distance,
//   strength and scan_ok; kind 0 is a point pair, kind 1 the end marker
// config port: cfg_we, cfg_index (0 header_lines, 1 expected_points), cfg_data
// throughput: one byte a cycle while in_ready is high (queue not full)
// path: each digit waits in the front end hold register for the next character,
//   then passes a queue entry and the output register
// a 4-entry request queue parts front end and decoder; when the receiver
//   stalls the queue fills and in_ready drops once it holds four requests
// reset: config returns to 3 header lines and 641 points, scan state clears,
//   queue and output register empty
// after each end marker the next scan starts again with its header
module range_scan_stream_decoder
    import rssd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [10:0] point_index,
    output logic [17:0] distance,
    output logic [17:0] strength,
    output logic        scan_ok,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [10:0] cfg_data
);

    logic [2:0]  header_lines_reg;
    logic [10:0] expected_points_reg;
    logic        accept;
    logic        push;
    rssd_cmd_t   push_cmd;
    logic        full;
    logic        pop;
    logic        pop_valid;
    rssd_cmd_t   pop_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_lines_reg    <= HEADER_LINES_RST;
            expected_points_reg <= EXPECTED_POINTS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEADER_LINES:    header_lines_reg    <= cfg_data[2:0];
                CFG_EXPECTED_POINTS: expected_points_reg <= cfg_data;
                default:             header_lines_reg    <= header_lines_reg;
            endcase
        end
    end

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    rssd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .rx_byte      (rx_byte),
        .header_lines (header_lines_reg),
        .push         (push),
        .cmd          (push_cmd)
    );

    rssd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_cmd   (pop_cmd)
    );

    rssd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (pop_valid),
        .cmd             (pop_cmd),
        .cmd_pop         (pop),
        .expected_points (expected_points_reg),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .point_index     (point_index),
        .distance        (distance),
        .strength        (strength),
        .scan_ok         (scan_ok)
    );

endmodule
